### rtl/core/cscan_disk_scheduler_defines.svh
`ifndef CSCAN_DISK_SCHEDULER_DEFINES_SVH
`define CSCAN_DISK_SCHEDULER_DEFINES_SVH

// Concurrent assertion that is switched off while the reset is applied.
`define CSCAN_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) \
		else $error(msg);

// Concurrent assertion that must also hold while the reset is applied.
`define CSCAN_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) (prop)) \
		else $error(msg);

`endif

### rtl/core/cscan_pkg.sv
`default_nettype none

package cscan_pkg;

	localparam int MAX_REQUESTS_DEF = 32;
	localparam int CYL_W = 16;
	localparam int SEEK_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CYL_W-1:0] DISK_CYL_RESET = 16'd200;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_RUN = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_DISK_CYLINDERS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_DOWN = 2'd1;

	typedef struct packed {
		logic add;
		logic run_start;
		logic ld_i;
		logic cap_i;
		logic scan;
		logic wr_sorted;
		logic emit_head;
		logic emit_step;
	} ctrl_t;

	typedef struct packed {
		logic n_zero;
		logic scan_last;
		logic rank_last;
		logic step_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

### rtl/core/cscan_if.sv
`default_nettype none

interface cscan_req_if import cscan_pkg::*;;
	logic valid;
	logic ready;
	logic cmd;
	logic [CYL_W-1:0] cylinder;

	modport source(output valid, output cmd, output cylinder, input ready);
	modport sink(input valid, input cmd, input cylinder, output ready);
endinterface

interface cscan_res_if import cscan_pkg::*;;
	logic valid;
	logic ready;
	logic [CYL_W-1:0] visited_cylinder;
	logic [SEEK_W-1:0] total_seek;
	logic last;
	logic overflow;

	modport source(output valid, output visited_cylinder, output total_seek, output last,
		output overflow, input ready);
	modport sink(input valid, input visited_cylinder, input total_seek, input last,
		input overflow, output ready);
endinterface

interface cscan_cfg_if import cscan_pkg::*;;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/cscan_ctrl.sv
`default_nettype none

module cscan_ctrl import cscan_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  req_valid,
	input  wire logic  req_cmd,
	input  wire stat_t stat,
	output logic       req_ready,
	output ctrl_t      ctrl
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOADI = 3'd1;
	localparam logic [2:0] S_CAPI  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_WRITE = 3'd4;
	localparam logic [2:0] S_HEAD  = 3'd5;
	localparam logic [2:0] S_SREAD = 3'd6;
	localparam logic [2:0] S_SEMIT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req_cmd == CMD_RUN) begin
						ctrl.run_start = 1'b1;
						state_d = stat.n_zero ? S_HEAD : S_LOADI;
					end else begin
						ctrl.add = 1'b1;
					end
				end
			end
			S_LOADI: begin
				ctrl.ld_i = 1'b1;
				state_d = S_CAPI;
			end
			S_CAPI: begin
				ctrl.cap_i = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				ctrl.scan = 1'b1;
				if (stat.scan_last) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				ctrl.wr_sorted = 1'b1;
				state_d = stat.rank_last ? S_HEAD : S_LOADI;
			end
			S_HEAD: begin
				if (stat.out_free) begin
					ctrl.emit_head = 1'b1;
					state_d = S_SREAD;
				end
			end
			S_SREAD: begin
				state_d = S_SEMIT;
			end
			S_SEMIT: begin
				if (stat.out_free) begin
					ctrl.emit_step = 1'b1;
					state_d = stat.step_last ? S_IDLE : S_SREAD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/cscan_dpath.sv
`default_nettype none
`include "cscan_disk_scheduler_defines.svh"

module cscan_dpath import cscan_pkg::*; #(
	parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [CYL_W-1:0]      cyl_in,
	input  wire logic                  cfg_wr,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire ctrl_t                 ctrl,
	input  wire logic                  res_ready,
	output stat_t                      stat,
	output logic                       res_valid,
	output logic [CYL_W-1:0]           res_visited_cylinder,
	output logic [SEEK_W-1:0]          res_total_seek,
	output logic                       res_last,
	output logic                       res_overflow
);

	localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CW = $clog2(MAX_REQUESTS + 3);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_REQUESTS);

	logic [CYL_W-1:0] store_mem [MAX_REQUESTS];
	logic [CYL_W-1:0] sorted_mem [MAX_REQUESTS];
	logic [CYL_W-1:0] store_rd_q;
	logic [CYL_W-1:0] sorted_rd_q;

	logic [CYL_W-1:0] disk_cyl_q;
	logic             sweep_down_q;
	logic [CW-1:0]    count_q;
	logic             dropped_q;
	logic             res_valid_q;

	logic [CYL_W-1:0]  head_q;
	logic [CYL_W-1:0]  ai_q;
	logic [CYL_W-1:0]  pos_q;
	logic [SEEK_W-1:0] total_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     j_q;
	logic [CW-1:0]     rank_q;
	logic [CW-1:0]     lcnt_q;
	logic [CW-1:0]     s_q;

	logic [CYL_W-1:0]  out_cyl_q;
	logic [SEEK_W-1:0] out_total_q;
	logic              out_last_q;
	logic              out_ovf_q;

	logic [CYL_W-1:0]  endc;
	logic [CW-1:0]     store_raddr;
	logic [CW-1:0]     bnd;
	logic              below;
	logic              is_c1;
	logic              is_wrap;
	logic [CW-1:0]     sort_raddr;
	logic [CYL_W-1:0]  step_val;
	logic [CYL_W-1:0]  seek_step;
	logic [SEEK_W-1:0] total_next;
	logic              out_free;

	assign endc = (disk_cyl_q == '0) ? '0 : disk_cyl_q - CYL_W'(1);
	assign out_free = !res_valid_q || res_ready;

	assign stat.n_zero    = (count_q == '0);
	assign stat.scan_last = (j_q == count_q - CW'(1));
	assign stat.rank_last = (i_q == count_q - CW'(1));
	assign stat.step_last = (s_q == count_q + CW'(1));
	assign stat.out_free  = out_free;

	always_comb begin
		if (ctrl.ld_i) begin
			store_raddr = i_q;
		end else if (ctrl.cap_i || stat.scan_last) begin
			store_raddr = '0;
		end else begin
			store_raddr = j_q + CW'(1);
		end
	end

	// The sweep visits one group, the appended end stop, the wrap stop and the other group.
	assign bnd     = sweep_down_q ? lcnt_q : count_q - lcnt_q;
	assign below   = (s_q < bnd);
	assign is_c1   = (s_q == bnd);
	assign is_wrap = (s_q == bnd + CW'(1));

	always_comb begin
		if (!sweep_down_q) begin
			sort_raddr = below ? lcnt_q + s_q : s_q - bnd - CW'(2);
		end else begin
			sort_raddr = below ? lcnt_q - CW'(1) - s_q : count_q + lcnt_q + CW'(1) - s_q;
		end
	end

	always_comb begin
		if (is_wrap) begin
			step_val = sweep_down_q ? endc : '0;
		end else if (is_c1) begin
			step_val = sweep_down_q ? '0 : endc;
		end else begin
			step_val = sorted_rd_q;
		end
	end

	assign seek_step = (step_val > pos_q) ? step_val - pos_q : pos_q - step_val;
	assign total_next = total_q + (is_wrap ? {{(SEEK_W-CYL_W){1'b0}}, endc}
		: {{(SEEK_W-CYL_W){1'b0}}, seek_step});

	always_ff @(posedge clk) begin
		store_rd_q <= store_mem[store_raddr[AW-1:0]];
		sorted_rd_q <= sorted_mem[sort_raddr[AW-1:0]];
		if (ctrl.add && count_q < MAX_C) begin
			store_mem[count_q[AW-1:0]] <= cyl_in;
		end
		if (ctrl.wr_sorted) begin
			sorted_mem[rank_q[AW-1:0]] <= ai_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.run_start) begin
			head_q <= cyl_in;
			i_q <= '0;
			lcnt_q <= '0;
		end
		if (ctrl.cap_i) begin
			ai_q <= store_rd_q;
			j_q <= '0;
			rank_q <= '0;
			if (store_rd_q < head_q) begin
				lcnt_q <= lcnt_q + CW'(1);
			end
		end
		if (ctrl.scan) begin
			j_q <= j_q + CW'(1);
			if (store_rd_q < ai_q || (store_rd_q == ai_q && j_q < i_q)) begin
				rank_q <= rank_q + CW'(1);
			end
		end
		if (ctrl.wr_sorted) begin
			i_q <= i_q + CW'(1);
		end
		if (ctrl.emit_head) begin
			out_cyl_q <= head_q;
			out_total_q <= '0;
			out_last_q <= 1'b0;
			out_ovf_q <= dropped_q;
			total_q <= '0;
			pos_q <= head_q;
			s_q <= '0;
		end
		if (ctrl.emit_step) begin
			out_cyl_q <= step_val;
			out_total_q <= total_next;
			out_last_q <= stat.step_last;
			out_ovf_q <= dropped_q;
			total_q <= total_next;
			pos_q <= step_val;
			s_q <= s_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_cyl_q <= DISK_CYL_RESET;
			sweep_down_q <= 1'b0;
			count_q <= '0;
			dropped_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					REG_DISK_CYLINDERS: begin
						disk_cyl_q <= cfg_data;
					end
					REG_SWEEP_DOWN: begin
						sweep_down_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			if (ctrl.add) begin
				if (count_q < MAX_C) begin
					count_q <= count_q + CW'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (ctrl.emit_step && stat.step_last) begin
				count_q <= '0;
				dropped_q <= 1'b0;
			end
			if (ctrl.emit_head || ctrl.emit_step) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_visited_cylinder = out_cyl_q;
	assign res_total_seek = out_total_q;
	assign res_last = out_last_q;
	assign res_overflow = out_ovf_q;

	`CSCAN_ASSERT_ALWAYS(a_count_bound, clk, !arst_n || count_q <= MAX_C, "request count above store depth")
	`CSCAN_ASSERT(a_drop_only_full, clk, arst_n, (ctrl.add && count_q != MAX_C && !dropped_q) |=> !dropped_q, "request dropped while store had room")
	`CSCAN_ASSERT(a_head_zero_seek, clk, arst_n, ctrl.emit_head |=> (res_valid && res_total_seek == '0 && !res_last), "start head word malformed")
	`CSCAN_ASSERT(a_run_clears, clk, arst_n, (ctrl.emit_step && stat.step_last) |=> (count_q == '0 && !dropped_q && res_valid && res_last), "run end did not clear store")

endmodule

`default_nettype wire

### rtl/core/cscan_disk_scheduler.sv
// Add command: accepted one per cycle while idle; it gives no word.
// Run command with n stored requests: each request is ranked by a load, a capture, a scan of
// all n stored requests and a sorted write, one store read a cycle; then come the start head
// word and n+2 further words, each held while the output is busy; the next item waits for the run.
// Reset is asynchronous and active low: it clears the request count, the drop flag and the
// output valid, and sets 200 cylinders with an upward sweep; stored requests are undefined.
`default_nettype none

module cscan_disk_scheduler import cscan_pkg::*; #(
	parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	cscan_req_if.sink   req,
	cscan_res_if.source res,
	cscan_cfg_if.sink   cfg
);

	ctrl_t ctrl;
	stat_t stat;

	assign cfg.ready = 1'b1;

	cscan_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.stat      (stat),
		.req_ready (req.ready),
		.ctrl      (ctrl)
	);

	cscan_dpath #(
		.MAX_REQUESTS (MAX_REQUESTS)
	) u_dpath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cyl_in               (req.cylinder),
		.cfg_wr               (cfg.valid),
		.cfg_index            (cfg.index),
		.cfg_data             (cfg.data),
		.ctrl                 (ctrl),
		.res_ready            (res.ready),
		.stat                 (stat),
		.res_valid            (res.valid),
		.res_visited_cylinder (res.visited_cylinder),
		.res_total_seek       (res.total_seek),
		.res_last             (res.last),
		.res_overflow         (res.overflow)
	);

endmodule

`default_nettype wire
